// ----- sv/modexp_pkg.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Sequencer states and reset constants shared by the exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

  // Reset value of the modulus register, before truncation to the value width
  localparam longint unsigned ModulusReset = 64'd1000000007;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,    // waiting for a request
    ST_REDUCE,  // base reduced modulo the modulus
    ST_SQUARE,  // running value squared
    ST_MULT,    // running value multiplied by the reduced base
    ST_HOLD     // result waits for the output register
  } state_e;

endpackage

// ----- sv/modexp_mulmod.sv -----
// ----------------------------------------------------------------------------
// Modular multiplier
// Shift-and-add modular product x * y mod m, one multiplier bit per cycle,
// MSB first. A modulus of zero gives the product wrapped to the value width.
// ----------------------------------------------------------------------------
module modexp_mulmod #(
  parameter int unsigned VALUE_WIDTH = 31
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] x_i,
  input  logic [VALUE_WIDTH-1:0] y_i,
  input  logic [VALUE_WIDTH-1:0] mod_i,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] prod_o
);

  localparam int unsigned CntW = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned SumW = VALUE_WIDTH + 2;

  logic                   busy_q, busy_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic [VALUE_WIDTH-1:0] x_q, x_d;
  logic [VALUE_WIDTH-1:0] y_q, y_d;

  logic [SumW-1:0]        sum;
  logic [SumW-1:0]        mod_ext;
  logic [SumW-1:0]        mod2_ext;
  logic [SumW-1:0]        sum_m1;
  logic [SumW-1:0]        sum_m2;
  logic [VALUE_WIDTH-1:0] step_val;

  assign done_o = busy_q && (cnt_q == '0);
  assign prod_o = acc_q;

  // One step: acc = (2*acc + ybit*x) mod m; sum stays below 3m
  always_comb begin
    sum      = {1'b0, acc_q, 1'b0} + (y_q[VALUE_WIDTH-1] ? {2'b00, x_q} : '0);
    mod_ext  = {2'b00, mod_i};
    mod2_ext = {1'b0, mod_i, 1'b0};
    sum_m1   = sum - mod_ext;
    sum_m2   = sum - mod2_ext;
    if (mod_i == '0) begin
      step_val = sum[VALUE_WIDTH-1:0];
    end else if (sum >= mod2_ext) begin
      step_val = sum_m2[VALUE_WIDTH-1:0];
    end else if (sum >= mod_ext) begin
      step_val = sum_m1[VALUE_WIDTH-1:0];
    end else begin
      step_val = sum[VALUE_WIDTH-1:0];
    end
  end

  // Operand load and bit iteration
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    x_d    = x_q;
    y_d    = y_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(VALUE_WIDTH);
      acc_d  = '0;
      x_d    = x_i;
      y_d    = y_i;
    end else if (done_o) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      acc_d = step_val;
      y_d   = {y_q[VALUE_WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
  end

endmodule

// ----- sv/modular_exponentiation.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation
// base_value ** exponent mod modulus by left-to-right square-and-multiply.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one word of base_value_i
//   and exponent_i. Output channel (out_valid_o / out_stall_i) returns one
//   word power_mod_o per request, in order. A word moves on a clock edge
//   with valid high and stall low.
//   The user is to write the modulus through cfg_valid_i / cfg_ready_o only
//   while the block is idle; the block itself does not enforce this, ready
//   is always high. Reset loads 1000000007 (truncated to VALUE_WIDTH) and
//   empties the output register. One shared modular multiplier computes
//   every product, one at a time. A request costs the base reduction plus
//   one squaring per exponent bit plus one multiply per set bit. A zero
//   exponent skips the multiplier and returns 1. The multiplier loop sets
//   the rate; one request is in work at a time, in_stall_o stays high
//   meanwhile. While the receiver stalls, the finished word sits in the
//   output register and the next request can run up to its own result.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int unsigned VALUE_WIDTH = 31
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [VALUE_WIDTH-1:0] cfg_modulus_i,
  // request channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [VALUE_WIDTH-1:0] base_value_i,
  input  logic [VALUE_WIDTH-1:0] exponent_i,
  // result channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [VALUE_WIDTH-1:0] power_mod_o
);

  localparam int unsigned BitW = $clog2(VALUE_WIDTH);

  modexp_pkg::state_e state_q, state_d;

  logic [VALUE_WIDTH-1:0] mod_q;
  logic [VALUE_WIDTH-1:0] a_q;
  logic [VALUE_WIDTH-1:0] e_q;
  logic [VALUE_WIDTH-1:0] r_q;
  logic [BitW-1:0]        bit_q;
  logic                   out_valid_q;
  logic [VALUE_WIDTH-1:0] out_q;

  logic                   accept;
  logic                   mul_start;
  logic [VALUE_WIDTH-1:0] mul_x;
  logic [VALUE_WIDTH-1:0] mul_y;
  logic                   mul_done;
  logic [VALUE_WIDTH-1:0] mul_prod;
  logic                   load_a;
  logic                   load_r;
  logic                   bit_dec;
  logic                   load_out;
  logic                   out_free;
  logic                   cur_bit;
  logic                   last_bit;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != modexp_pkg::ST_IDLE);
  assign accept      = in_valid_i && (state_q == modexp_pkg::ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cur_bit     = e_q[bit_q];
  assign last_bit    = (bit_q == '0);
  assign out_valid_o = out_valid_q;
  assign power_mod_o = out_q;

  // Shared modular multiplier
  modexp_mulmod #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .x_i    (mul_x),
    .y_i    (mul_y),
    .mod_i  (mod_q),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      modexp_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (exponent_i == '0) ? modexp_pkg::ST_HOLD : modexp_pkg::ST_REDUCE;
        end
      end
      modexp_pkg::ST_REDUCE: begin
        if (mul_done) state_d = modexp_pkg::ST_SQUARE;
      end
      modexp_pkg::ST_SQUARE: begin
        if (mul_done) begin
          if (cur_bit)       state_d = modexp_pkg::ST_MULT;
          else if (last_bit) state_d = modexp_pkg::ST_HOLD;
        end
      end
      modexp_pkg::ST_MULT: begin
        if (mul_done) state_d = last_bit ? modexp_pkg::ST_HOLD : modexp_pkg::ST_SQUARE;
      end
      modexp_pkg::ST_HOLD: begin
        if (out_free) state_d = modexp_pkg::ST_IDLE;
      end
      default: state_d = modexp_pkg::ST_IDLE;
    endcase
  end

  // Multiplier commands and register loads
  always_comb begin
    mul_start = 1'b0;
    mul_x     = mul_prod;
    mul_y     = mul_prod;
    load_a    = 1'b0;
    load_r    = 1'b0;
    bit_dec   = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      modexp_pkg::ST_IDLE: begin
        // base mod m as the product 1 * base
        mul_x     = VALUE_WIDTH'(1);
        mul_y     = base_value_i;
        mul_start = accept && (exponent_i != '0);
      end
      modexp_pkg::ST_REDUCE: begin
        mul_x     = r_q;
        mul_y     = r_q;
        mul_start = mul_done;
        load_a    = mul_done;
      end
      modexp_pkg::ST_SQUARE: begin
        load_r = mul_done;
        if (cur_bit) begin
          mul_x     = a_q;
          mul_start = mul_done;
        end else begin
          mul_start = mul_done && !last_bit;
          bit_dec   = mul_done && !last_bit;
        end
      end
      modexp_pkg::ST_MULT: begin
        load_r    = mul_done;
        mul_start = mul_done && !last_bit;
        bit_dec   = mul_done && !last_bit;
      end
      modexp_pkg::ST_HOLD: begin
        load_out = out_free;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= modexp_pkg::ST_IDLE;
      mod_q       <= VALUE_WIDTH'(modexp_pkg::ModulusReset);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) mod_q <= cfg_modulus_i;
      if (load_out)          out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      e_q   <= exponent_i;
      r_q   <= VALUE_WIDTH'(1);
      bit_q <= BitW'(VALUE_WIDTH - 1);
    end else begin
      if (load_r)  r_q   <= mul_prod;
      if (bit_dec) bit_q <= bit_q - 1'b1;
    end
    if (load_a)   a_q   <= mul_prod;
    if (load_out) out_q <= r_q;
  end

`ifndef SYNTHESIS
  // A finished nonzero power is fully reduced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && (mod_q > VALUE_WIDTH'(1)) && (e_q != '0) |-> r_q < mod_q)
    else $error("result not reduced below modulus");

  // The multiplier only finishes while the sequencer waits on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == modexp_pkg::ST_REDUCE) || (state_q == modexp_pkg::ST_SQUARE) ||
                 (state_q == modexp_pkg::ST_MULT))
    else $error("multiplier done outside a compute state");

  // A zero exponent goes straight to the result with value one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (exponent_i == '0) |=>
      (state_q == modexp_pkg::ST_HOLD) && (r_q == VALUE_WIDTH'(1)))
    else $error("zero exponent not short-cut to one");
`endif

endmodule
